@@ rtl/ahp_pkg.sv @@
// ahp_pkg: shared types, codes and lookup tables of the audio header probe
`timescale 1ns / 1ps
package ahp_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CORRUPT = 2'd1;
    localparam logic [1:0] ST_UNSUP   = 2'd2;

    localparam logic KIND_WAV = 1'b0;
    localparam logic KIND_MP3 = 1'b1;

    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;

    localparam int NUM_W = 42;
    localparam int DEN_W = 18;
    localparam logic [5:0] DIV_LAST = 6'(NUM_W - 1);

    typedef enum logic [2:0] {
        PH_RIFF, PH_HEAD, PH_FMT, PH_SKIP, PH_DATA, PH_BAD
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE, BK_EVAL, BK_DIV, BK_DONE
    } t_back_state;

    // summary of one closed stream, handed from front to back
    typedef struct packed {
        logic        riff_ok;
        logic        phase_riff;
        logic        fmt_cut;
        logic [2:0]  seen;
        logic [15:0] format_code;
        logic [15:0] chan_field;
        logic [31:0] rate_field;
        logic [15:0] sample_bits;
        logic [31:0] wav_off;
        logic [31:0] wav_len;
        logic        sync_found;
        logic [31:0] sync_pos;
        logic [23:0] frame_header;
        logic [31:0] size;
    } t_probe_rec;

    function automatic logic [7:0] riff_magic(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h52;
            2'd1:    v = 8'h49;
            default: v = 8'h46;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] wave_magic(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h57;
            2'd1:    v = 8'h41;
            2'd2:    v = 8'h56;
            default: v = 8'h45;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] kbps_lookup(input logic v1, input logic [3:0] br);
        logic [8:0] k;
        if (v1) begin
            case (br)
                4'd1:  k = 9'd32;  4'd2:  k = 9'd40;  4'd3:  k = 9'd48;
                4'd4:  k = 9'd56;  4'd5:  k = 9'd64;  4'd6:  k = 9'd80;
                4'd7:  k = 9'd96;  4'd8:  k = 9'd112; 4'd9:  k = 9'd128;
                4'd10: k = 9'd160; 4'd11: k = 9'd192; 4'd12: k = 9'd224;
                4'd13: k = 9'd256; 4'd14: k = 9'd320;
                default: k = 9'd0;
            endcase
        end else begin
            case (br)
                4'd1:  k = 9'd8;   4'd2:  k = 9'd16;  4'd3:  k = 9'd24;
                4'd4:  k = 9'd32;  4'd5:  k = 9'd40;  4'd6:  k = 9'd48;
                4'd7:  k = 9'd56;  4'd8:  k = 9'd64;  4'd9:  k = 9'd80;
                4'd10: k = 9'd96;  4'd11: k = 9'd112; 4'd12: k = 9'd128;
                4'd13: k = 9'd144; 4'd14: k = 9'd160;
                default: k = 9'd0;
            endcase
        end
        return k;
    endfunction

    // rate code 3 folds onto code 0
    function automatic logic [15:0] mp3_rate(input logic [1:0] mpeg, input logic [1:0] sr);
        logic [15:0] r;
        case ({mpeg, sr})
            4'b00_00, 4'b00_11: r = 16'd44100;
            4'b00_01:           r = 16'd48000;
            4'b00_10:           r = 16'd32000;
            4'b01_00, 4'b01_11: r = 16'd22050;
            4'b01_01:           r = 16'd24000;
            4'b01_10:           r = 16'd16000;
            4'b10_01:           r = 16'd12000;
            4'b10_10:           r = 16'd8000;
            default:            r = 16'd11025;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/ahp_front.sv @@
// ahp_front: byte parser tracking the riff chunk walk and the mp3 sync search
`timescale 1ns / 1ps
module ahp_front
    import ahp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_push,
    output t_probe_rec o_rec
);

    logic [31:0] r_byte_count, n_byte_count;
    logic        r_riff_ok, n_riff_ok;
    t_phase      r_phase, n_phase;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [31:0] r_cpos, n_cpos;
    logic [15:0] r_format, n_format;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [2:0]  r_seen, n_seen;
    logic [31:0] r_woff, n_woff;
    logic [31:0] r_wlen, n_wlen;
    logic [23:0] r_win, n_win;
    logic        r_found, n_found;
    logic [31:0] r_spos, n_spos;
    logic [23:0] r_fh, n_fh;

    always_comb begin
        logic [31:0] pos;
        logic [7:0]  b;
        logic [2:0]  idx;
        logic [32:0] padded;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic        riff;
        pos = r_byte_count;
        b   = i_data_byte;
        idx = r_cpos[2:0];
        padded = ({1'b0, r_len} + 33'd1) & ~33'd1;
        b0 = r_win[15:8];
        b1 = r_win[7:0];
        riff = r_riff_ok;

        n_byte_count = r_byte_count;
        n_riff_ok = r_riff_ok;
        n_phase = r_phase;
        n_tag = r_tag;
        n_len = r_len;
        n_cpos = r_cpos;
        n_format = r_format;
        n_chan = r_chan;
        n_rate = r_rate;
        n_bits = r_bits;
        n_seen = r_seen;
        n_woff = r_woff;
        n_wlen = r_wlen;
        n_win = r_win;
        n_found = r_found;
        n_spos = r_spos;
        n_fh = r_fh;
        o_push = 1'b0;
        o_rec = '0;

        if (i_accept) begin
            case (r_phase)
                PH_RIFF: begin
                    if (pos < 32'd4 && b != riff_magic(pos[1:0])) riff = 1'b0;
                    if (pos >= 32'd8 && pos < 32'd12 && b != wave_magic(pos[1:0]))
                        riff = 1'b0;
                    n_riff_ok = riff;
                    if (pos >= 32'd11) n_phase = riff ? PH_HEAD : PH_BAD;
                end
                PH_HEAD: begin
                    if (idx == 3'd0) begin
                        n_tag = {24'd0, b};
                        n_len = '0;
                    end else if (idx < 3'd4) begin
                        n_tag = {r_tag[23:0], b};
                    end else begin
                        n_len[8*idx[1:0] +: 8] = b;
                    end
                    if (idx < 3'd7) begin
                        n_cpos = {29'd0, idx + 3'd1};
                    end else begin
                        // chunk header complete
                        n_cpos = '0;
                        if (n_tag == TAG_FMT) begin
                            if (n_len < 32'd16) begin
                                n_phase = PH_BAD;
                                n_seen[2] = 1'b1;
                            end else begin
                                n_phase = PH_FMT;
                            end
                        end else if (n_tag == TAG_DATA) begin
                            n_woff = (pos == SAT32) ? SAT32 : pos + 32'd1;
                            n_wlen = n_len;
                            n_seen[1] = 1'b1;
                            n_phase = PH_DATA;
                        end else begin
                            n_phase = (n_len == 32'd0) ? PH_HEAD : PH_SKIP;
                        end
                    end
                end
                PH_FMT, PH_SKIP: begin
                    if (r_phase == PH_FMT) begin
                        case (r_cpos)
                            32'd0:  n_format = {8'd0, b};
                            32'd1:  n_format[15:8] = b;
                            32'd2:  n_chan = {8'd0, b};
                            32'd3:  n_chan[15:8] = b;
                            32'd4:  n_rate = {24'd0, b};
                            32'd5:  n_rate[15:8] = b;
                            32'd6:  n_rate[23:16] = b;
                            32'd7:  n_rate[31:24] = b;
                            32'd14: n_bits = {8'd0, b};
                            32'd15: begin
                                n_bits[15:8] = b;
                                n_seen[0] = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    // padded body walk
                    if ({1'b0, r_cpos} + 33'd1 >= padded) begin
                        n_phase = PH_HEAD;
                        n_cpos = '0;
                    end else begin
                        n_cpos = r_cpos + 32'd1;
                    end
                end
                default: ;
            endcase

            n_win = {r_win[15:0], b};
            if (!r_found && pos >= 32'd2) begin
                if (b0 == 8'hFF && b1[7:5] == 3'b111 && b1[2:1] == 2'b01 &&
                    b[3:2] != 2'b11 && b1[4:3] != 2'b01) begin
                    n_found = 1'b1;
                    n_spos = pos - 32'd2;
                    n_fh = {b1, b, 8'd0};
                end
            end else if (r_found && {1'b0, pos} == {1'b0, r_spos} + 33'd3) begin
                n_fh[7:0] = b;
            end

            if (r_byte_count != SAT32) n_byte_count = r_byte_count + 32'd1;

            if (i_last_byte) begin
                o_push = 1'b1;
                o_rec.riff_ok = n_riff_ok;
                o_rec.phase_riff = (n_phase == PH_RIFF);
                o_rec.fmt_cut = (n_phase == PH_FMT) && (n_cpos < 32'd16);
                o_rec.seen = n_seen;
                o_rec.format_code = n_format;
                o_rec.chan_field = n_chan;
                o_rec.rate_field = n_rate;
                o_rec.sample_bits = n_bits;
                o_rec.wav_off = n_woff;
                o_rec.wav_len = n_wlen;
                o_rec.sync_found = n_found;
                o_rec.sync_pos = n_spos;
                o_rec.frame_header = n_fh;
                o_rec.size = n_byte_count;
                // next stream starts clean
                n_byte_count = '0;
                n_riff_ok = 1'b1;
                n_phase = PH_RIFF;
                n_tag = '0;
                n_len = '0;
                n_cpos = '0;
                n_format = '0;
                n_chan = '0;
                n_rate = '0;
                n_bits = '0;
                n_seen = '0;
                n_woff = '0;
                n_wlen = '0;
                n_win = '0;
                n_found = 1'b0;
                n_spos = '0;
                n_fh = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_riff_ok <= 1'b1;
            r_phase <= PH_RIFF;
            r_tag <= '0;
            r_len <= '0;
            r_cpos <= '0;
            r_format <= '0;
            r_chan <= '0;
            r_rate <= '0;
            r_bits <= '0;
            r_seen <= '0;
            r_woff <= '0;
            r_wlen <= '0;
            r_win <= '0;
            r_found <= 1'b0;
            r_spos <= '0;
            r_fh <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            r_riff_ok <= n_riff_ok;
            r_phase <= n_phase;
            r_tag <= n_tag;
            r_len <= n_len;
            r_cpos <= n_cpos;
            r_format <= n_format;
            r_chan <= n_chan;
            r_rate <= n_rate;
            r_bits <= n_bits;
            r_seen <= n_seen;
            r_woff <= n_woff;
            r_wlen <= n_wlen;
            r_win <= n_win;
            r_found <= n_found;
            r_spos <= n_spos;
            r_fh <= n_fh;
        end
    end

endmodule

@@ rtl/ahp_queue.sv @@
// ahp_queue: two-entry queue of stream summaries between front and back
`timescale 1ns / 1ps
module ahp_queue
    import ahp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_probe_rec i_rec,
    input  logic       i_pop,
    output t_probe_rec o_rec,
    output logic       o_full,
    output logic       o_empty
);

    t_probe_rec r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rec   = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 2'd1;
        else if (!i_push && i_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ rtl/ahp_back.sv @@
// ahp_back: result evaluation, duration divider and output register
`timescale 1ns / 1ps
module ahp_back
    import ahp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_probe_rec  i_rec,
    input  logic        i_empty,
    output logic        o_pop,
    input  logic        i_ready,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_stream_kind,
    output logic [1:0]  o_channel_count,
    output logic [15:0] o_sample_rate_hz,
    output logic [31:0] o_data_offset,
    output logic [31:0] o_data_length,
    output logic [31:0] o_duration_ms
);

    t_back_state r_state, n_state;
    t_probe_rec  r_rec;
    logic [1:0]  r_status;
    logic        r_kind;
    logic [1:0]  r_chan;
    logic [15:0] r_rate;
    logic [31:0] r_off, r_len;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [5:0]  r_cnt;

    // evaluation of a popped summary
    logic [1:0]       e_status;
    logic             e_kind;
    logic [1:0]       e_chan;
    logic [15:0]      e_rate;
    logic [31:0]      e_off, e_len;
    logic [NUM_W-1:0] e_num;
    logic [DEN_W-1:0] e_den;

    always_comb begin
        logic        wav;
        logic [32:0] sum;
        logic [1:0]  ver, sr, mode, mpeg;
        logic [8:0]  kbps;
        wav = r_rec.riff_ok && !r_rec.phase_riff;
        sum = {1'b0, r_rec.wav_off} + {1'b0, r_rec.wav_len};
        ver = r_rec.frame_header[20:19];
        sr = r_rec.frame_header[11:10];
        mode = r_rec.frame_header[7:6];
        mpeg = (ver == 2'd3) ? 2'd0 : (ver == 2'd2) ? 2'd1 : 2'd2;
        kbps = kbps_lookup(mpeg == 2'd0, r_rec.frame_header[15:12]);
        e_status = ST_OK;
        e_kind = KIND_WAV;
        e_chan = '0;
        e_rate = '0;
        e_off = '0;
        e_len = '0;
        e_num = '0;
        e_den = '0;
        if (wav) begin
            if (r_rec.seen[2] || r_rec.fmt_cut || !r_rec.seen[0] || !r_rec.seen[1]) begin
                e_status = ST_CORRUPT;
            end else if (r_rec.format_code != 16'd1 ||
                         (r_rec.chan_field != 16'd1 && r_rec.chan_field != 16'd2) ||
                         r_rec.sample_bits != 16'd16 || r_rec.rate_field < 32'd8000 ||
                         r_rec.rate_field > 32'd48000) begin
                e_status = ST_UNSUP;
            end else begin
                e_chan = r_rec.chan_field[1:0];
                e_rate = r_rec.rate_field[15:0];
                e_off = r_rec.wav_off;
                e_len = r_rec.wav_len;
                if (sum > {1'b0, r_rec.size})
                    e_len = (r_rec.size >= r_rec.wav_off) ? r_rec.size - r_rec.wav_off : '0;
                // len * 1000 as shifts
                e_num = ({e_len, 10'd0}) - ({6'd0, e_len, 4'd0}) - ({7'd0, e_len, 3'd0});
                // rate * chan * 2
                e_den = (e_chan == 2'd2) ? {r_rec.rate_field[15:0], 2'd0}
                                         : {1'b0, r_rec.rate_field[15:0], 1'b0};
            end
        end else if (!r_rec.sync_found ||
                     {2'd0, r_rec.size} < {2'd0, r_rec.sync_pos} + 34'd4) begin
            e_status = ST_CORRUPT;
        end else begin
            e_kind = KIND_MP3;
            e_chan = (mode == 2'd3) ? 2'd1 : 2'd2;
            e_rate = mp3_rate(mpeg, sr);
            e_off = r_rec.sync_pos;
            e_len = r_rec.size - r_rec.sync_pos;
            e_num = {7'd0, e_len, 3'd0};
            e_den = {9'd0, kbps};
        end
    end

    // restoring divider step
    logic [DEN_W:0] d_shift;
    logic           d_fit;
    assign d_shift = {r_rem, r_num[NUM_W-1]};
    assign d_fit = d_shift >= {1'b0, r_den};

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (!i_empty) n_state = BK_EVAL;
            BK_EVAL: n_state = (e_status == ST_OK && e_den != '0) ? BK_DIV : BK_DONE;
            BK_DIV:  if (r_cnt == 6'd0) n_state = BK_DONE;
            BK_DONE: if (i_ready) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == BK_IDLE) && !i_empty;
        o_valid = (r_state == BK_DONE);
    end

    assign o_status = r_status;
    assign o_stream_kind = r_kind;
    assign o_channel_count = r_chan;
    assign o_sample_rate_hz = r_rate;
    assign o_data_offset = r_off;
    assign o_data_length = r_len;
    assign o_duration_ms = r_num[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_rec <= i_rec;
        case (r_state)
            BK_EVAL: begin
                r_status <= e_status;
                r_kind <= e_kind;
                r_chan <= e_chan;
                r_rate <= e_rate;
                r_off <= e_off;
                r_len <= e_len;
                r_num <= (e_den != '0) ? e_num : '0;
                r_den <= e_den;
                r_rem <= '0;
                r_cnt <= DIV_LAST;
            end
            BK_DIV: begin
                r_rem <= d_fit ? DEN_W'(d_shift - {1'b0, r_den}) : d_shift[DEN_W-1:0];
                r_num <= {r_num[NUM_W-2:0], d_fit};
                r_cnt <= r_cnt - 6'd1;
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_DIV |-> r_den != '0)
        else $error("divider running with zero divisor");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_channel_count == 2'd0 &&
            o_sample_rate_hz == 16'd0 && o_data_length == 32'd0 && o_duration_ms == 32'd0)
        else $error("failed stream carries nonzero fields");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == BK_DIV || $past(r_state) == BK_EVAL)
        else $error("result shown without evaluation");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == BK_EVAL)
        else $error("popped summary not evaluated");

endmodule

@@ rtl/audio_header_probe_unit.sv @@
// audio_header_probe_unit: top level of the wav / mp3 header probe
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | i_valid, o_ready, i_data_byte, i_last_byte | in
//  out     | o_valid, i_ready, o_status .. o_duration_ms | out
//
// the front takes one byte word per cycle; o_ready drops only while two
// closed streams wait in the queue. after the last byte of a stream the
// back pops its summary, evaluates it and, when a duration is divided, runs
// the bit-serial duration divider, which is skipped otherwise.
// results wait in the output register until taken.
// synchronous active-low reset clears the parser, queue and back state.
`timescale 1ns / 1ps
module audio_header_probe_unit
    import ahp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_stream_kind,
    output logic [1:0]  o_channel_count,
    output logic [15:0] o_sample_rate_hz,
    output logic [31:0] o_data_offset,
    output logic [31:0] o_data_length,
    output logic [31:0] o_duration_ms
);

    logic       push, pop, full, empty;
    t_probe_rec front_rec, queue_rec;

    assign o_ready = !full;

    ahp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_valid && o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_rec       (front_rec)
    );

    ahp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_rec   (queue_rec),
        .o_full  (full),
        .o_empty (empty)
    );

    ahp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rec            (queue_rec),
        .i_empty          (empty),
        .o_pop            (pop),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_stream_kind    (o_stream_kind),
        .o_channel_count  (o_channel_count),
        .o_sample_rate_hz (o_sample_rate_hz),
        .o_data_offset    (o_data_offset),
        .o_data_length    (o_data_length),
        .o_duration_ms    (o_duration_ms)
    );

endmodule

@@ test/tb_audio_header_probe_unit.sv @@
// tb_audio_header_probe_unit: streams wav / mp3 file heads through the probe and checks each result
`timescale 1ns / 1ps
module tb_audio_header_probe_unit;
    import ahp_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int CYCLE_CAP  = 600000;
    localparam int DRAIN_WAIT = 80;

    typedef struct {
        logic [1:0]  status;
        logic        kind;
        logic [1:0]  chans;
        logic [15:0] rate;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] dur_ms;
    } probe_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic        o_stream_kind;
    logic [1:0]  o_channel_count;
    logic [15:0] o_sample_rate_hz;
    logic [31:0] o_data_offset;
    logic [31:0] o_data_length;
    logic [31:0] o_duration_ms;

    audio_header_probe_unit u_dut (.*);

    // predictor state, one copy of the parser
    logic [31:0] pr_count;
    logic        pr_riff_ok;
    t_phase      pr_phase;
    logic [31:0] pr_tag, pr_clen, pr_cpos;
    logic [15:0] pr_fmt, pr_chan, pr_bits;
    logic [31:0] pr_rate;
    logic [2:0]  pr_seen;
    logic [31:0] pr_woff, pr_wlen;
    logic [23:0] pr_win;
    logic        pr_sync;
    logic [31:0] pr_spos;
    logic [23:0] pr_fhdr;

    probe_result_t expected_results[$];
    logic [7:0]    file_bytes[$];

    int err_count, result_count, words_sent, streams_sent, cycle_count;
    int ok_seen, corrupt_seen, unsup_seen, mp3_seen;
    int send_idle_pct, recv_idle_pct, hold_left;

    logic [7:0]  riff_id [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
    logic [7:0]  wave_id [4] = '{8'h57, 8'h41, 8'h56, 8'h45};
    logic [8:0]  kbps_v1 [16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256,
                                  320, 0};
    logic [8:0]  kbps_v2 [16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144,
                                  160, 0};
    logic [15:0] mp3_hz [3][3] = '{'{44100, 48000, 32000}, '{22050, 24000, 16000},
                                   '{11025, 12000, 8000}};

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_audio_header_probe_unit: errors");
            $finish;
        end
    end

    // receiver side, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready = 1'b0;
            hold_left--;
        end else begin
            i_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic probe_clear();
        pr_count = 0; pr_riff_ok = 1'b1; pr_phase = PH_RIFF;
        pr_tag = 0; pr_clen = 0; pr_cpos = 0;
        pr_fmt = 0; pr_chan = 0; pr_rate = 0; pr_bits = 0; pr_seen = 0;
        pr_woff = 0; pr_wlen = 0; pr_win = 0; pr_sync = 0; pr_spos = 0; pr_fhdr = 0;
    endtask

    task automatic chunk_body_step();
        logic [32:0] padded;
        padded = ({1'b0, pr_clen} + 33'd1) & ~33'd1;
        if ({1'b0, pr_cpos} + 33'd1 >= padded) begin
            pr_phase = PH_HEAD;
            pr_cpos = 0;
        end else begin
            pr_cpos++;
        end
    endtask

    task automatic probe_finish(output probe_result_t r);
        logic [63:0] size, len;
        logic [31:0] den;
        logic [1:0]  ver, sr, mode, mpeg;
        logic [3:0]  br;
        logic [8:0]  kbps;
        size = {32'd0, pr_count};
        r = '{default: '0};
        if (pr_riff_ok && pr_phase != PH_RIFF) begin
            len = {32'd0, pr_wlen};
            if (pr_seen[2] || (pr_phase == PH_FMT && pr_cpos < 16) || !pr_seen[0] || !pr_seen[1])
                r.status = ST_CORRUPT;
            else if (pr_fmt != 1 || (pr_chan != 1 && pr_chan != 2) || pr_bits != 16 ||
                     pr_rate < 8000 || pr_rate > 48000)
                r.status = ST_UNSUP;
            else begin
                if ({32'd0, pr_woff} + len > size)
                    len = (size >= {32'd0, pr_woff}) ? size - {32'd0, pr_woff} : 64'd0;
                den = pr_rate * {16'd0, pr_chan} * 32'd2;
                r.status = ST_OK;
                r.kind   = KIND_WAV;
                r.chans  = pr_chan[1:0];
                r.rate   = pr_rate[15:0];
                r.offset = pr_woff;
                r.length = len[31:0];
                r.dur_ms = 32'((len * 64'd1000) / {32'd0, den});
            end
        end else if (!pr_sync || size < {32'd0, pr_spos} + 64'd4) begin
            r.status = ST_CORRUPT;
        end else begin
            ver  = pr_fhdr[20:19];
            sr   = pr_fhdr[11:10];
            br   = pr_fhdr[15:12];
            mode = pr_fhdr[7:6];
            mpeg = (ver == 2'd3) ? 2'd0 : (ver == 2'd2) ? 2'd1 : 2'd2;
            kbps = (mpeg == 2'd0) ? kbps_v1[br] : kbps_v2[br];
            len  = size - {32'd0, pr_spos};
            r.status = ST_OK;
            r.kind   = KIND_MP3;
            r.chans  = (mode == 2'd3) ? 2'd1 : 2'd2;
            r.rate   = mp3_hz[mpeg][sr % 3];
            r.offset = pr_spos;
            r.length = len[31:0];
            r.dur_ms = (kbps != 0) ? 32'((len * 64'd8) / {55'd0, kbps}) : 32'd0;
        end
    endtask

    // advance the predictor by one accepted word
    task automatic probe_word(input logic [7:0] b, input logic last);
        logic [31:0]   pos, idx, body;
        logic [7:0]    b0, b1;
        probe_result_t r;
        pos = pr_count;
        idx = pr_cpos;
        case (pr_phase)
            PH_RIFF: begin
                if (pos < 4 && b != riff_id[pos[1:0]]) pr_riff_ok = 1'b0;
                if (pos >= 8 && pos < 12 && b != wave_id[pos[1:0]]) pr_riff_ok = 1'b0;
                if (pos >= 11) pr_phase = pr_riff_ok ? PH_HEAD : PH_BAD;
            end
            PH_HEAD: begin
                idx = idx & 32'd7;
                if (idx == 0) begin
                    pr_tag = {24'd0, b};
                    pr_clen = 0;
                end else if (idx < 4) begin
                    pr_tag = {pr_tag[23:0], b};
                end else begin
                    pr_clen |= {24'd0, b} << (8 * (idx - 4));
                end
                if (idx < 7) begin
                    pr_cpos = idx + 1;
                end else begin
                    body = (pos == SAT32) ? SAT32 : pos + 1;
                    pr_cpos = 0;
                    if (pr_tag == TAG_FMT) begin
                        pr_phase = (pr_clen < 16) ? PH_BAD : PH_FMT;
                        if (pr_clen < 16) pr_seen[2] = 1'b1;
                    end else if (pr_tag == TAG_DATA) begin
                        pr_woff = body;
                        pr_wlen = pr_clen;
                        pr_seen[1] = 1'b1;
                        pr_phase = PH_DATA;
                    end else begin
                        pr_phase = (pr_clen == 0) ? PH_HEAD : PH_SKIP;
                    end
                end
            end
            PH_FMT: begin
                if (idx == 0) pr_fmt = {8'd0, b};
                else if (idx == 1) pr_fmt[15:8] = b;
                else if (idx == 2) pr_chan = {8'd0, b};
                else if (idx == 3) pr_chan[15:8] = b;
                else if (idx == 4) pr_rate = {24'd0, b};
                else if (idx < 8) pr_rate |= {24'd0, b} << (8 * (idx - 4));
                else if (idx == 14) pr_bits = {8'd0, b};
                else if (idx == 15) begin
                    pr_bits[15:8] = b;
                    pr_seen[0] = 1'b1;
                end
                chunk_body_step();
            end
            PH_SKIP: chunk_body_step();
            default: ;
        endcase
        // frame sync search runs on every word
        pr_win = {pr_win[15:0], b};
        b0 = pr_win[23:16];
        b1 = pr_win[15:8];
        if (!pr_sync && pos >= 2) begin
            if (b0 == 8'hFF && b1[7:5] == 3'b111 && b1[2:1] == 2'b01 && b[3:2] != 2'b11 &&
                b1[4:3] != 2'b01) begin
                pr_sync = 1'b1;
                pr_spos = pos - 2;
                pr_fhdr = {b1, b, 8'd0};
            end
        end else if (pr_sync && {32'd0, pos} == {32'd0, pr_spos} + 64'd3) begin
            pr_fhdr[7:0] = b;
        end
        if (pr_count != SAT32) pr_count++;
        if (last) begin
            probe_finish(r);
            expected_results.push_back(r);
            probe_clear();
        end
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        err_count++;
        $display("mismatch result %0d %s: got %0d, want %0d", result_count, field, got, want);
    endtask

    always @(posedge i_clk) begin
        probe_result_t w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected result, status", {30'd0, o_status}, 32'd0);
            end else begin
                w = expected_results.pop_front();
                if (o_status !== w.status) report("status", o_status, w.status);
                if (o_stream_kind !== w.kind) report("stream_kind", o_stream_kind, w.kind);
                if (o_channel_count !== w.chans) report("channels", o_channel_count, w.chans);
                if (o_sample_rate_hz !== w.rate) report("rate", o_sample_rate_hz, w.rate);
                if (o_data_offset !== w.offset) report("offset", o_data_offset, w.offset);
                if (o_data_length !== w.length) report("length", o_data_length, w.length);
                if (o_duration_ms !== w.dur_ms) report("duration", o_duration_ms, w.dur_ms);
                case (w.status)
                    ST_OK:      ok_seen++;
                    ST_CORRUPT: corrupt_seen++;
                    default:    unsup_seen++;
                endcase
                if (w.status == ST_OK && w.kind == KIND_MP3) mp3_seen++;
            end
            result_count++;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        do @(posedge i_clk); while (!o_ready);
        probe_word(b, last);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) send_word(file_bytes[i], i == file_bytes.size() - 1);
        streams_sent++;
    endtask

    task automatic add_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic add_tag(input logic [31:0] t);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(t[8*i +: 8]);
    endtask

    task automatic add_noise(input int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endtask

    task automatic build_wav(input logic [15:0] fmtc, input logic [15:0] ch,
                             input logic [31:0] rate, input logic [15:0] bits,
                             input int fmtlen, input logic [31:0] dlen,
                             input int payload, input int extra_len);
        file_bytes.delete();
        add_tag(32'h5249_4646);
        add_le(32'(36 + payload), 4);
        add_tag(32'h5741_5645);
        // optional unknown chunk ahead of fmt, odd lengths get a pad word
        if (extra_len >= 0) begin
            add_tag(32'h4C49_5354);
            add_le(extra_len, 4);
            add_noise(extra_len + extra_len % 2);
        end
        add_tag(TAG_FMT);
        add_le(fmtlen, 4);
        add_le(fmtc, 2);
        add_le(ch, 2);
        add_le(rate, 4);
        add_le(rate * ch * 2, 4);
        add_le(ch * 2, 2);
        add_le(bits, 2);
        if (fmtlen < 16) repeat (16 - fmtlen) void'(file_bytes.pop_back());
        else add_noise(fmtlen - 16 + fmtlen % 2);
        add_tag(TAG_DATA);
        add_le(dlen, 4);
        add_noise(payload);
    endtask

    task automatic build_mp3(input int junk, input logic [7:0] b1, input logic [7:0] b2,
                             input logic [7:0] b3, input int tail);
        file_bytes.delete();
        add_noise(junk);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(b1);
        file_bytes.push_back(b2);
        file_bytes.push_back(b3);
        add_noise(tail);
    endtask

    task automatic cut_file(input int keep);
        while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    endtask

    task automatic test_wave_directed();
        build_wav(1, 2, 44100, 16, 16, 8, 8, -1);           send_file();
        build_wav(1, 1, 8000, 16, 16, SAT32, 6, -1);        send_file();
        build_wav(1, 2, 48000, 16, 18, 4, 10, 3);           send_file();
        build_wav(1, 1, 22050, 16, 16, 0, 0, 0);            send_file();
        build_wav(1, 2, 7999, 16, 16, 4, 4, -1);            send_file();
        build_wav(1, 2, 48001, 16, 16, 4, 4, -1);           send_file();
        build_wav(3, 2, 44100, 16, 16, 4, 4, -1);           send_file();
        build_wav(1, 3, 44100, 16, 16, 4, 4, -1);           send_file();
        build_wav(1, 0, 44100, 16, 16, 4, 4, -1);           send_file();
        build_wav(1, 2, 44100, 8, 16, 4, 4, -1);            send_file();
        // fmt shorter than its fields
        build_wav(1, 2, 44100, 16, 14, 4, 4, -1);           send_file();
        // fmt body cut by the stream end
        build_wav(1, 2, 44100, 16, 16, 4, 4, -1); cut_file(30); send_file();
        // data header never completes
        build_wav(1, 2, 44100, 16, 16, 4, 4, -1); cut_file(42); send_file();
    endtask

    task automatic test_mp3_directed();
        build_mp3(3, 8'hFB, 8'h90, 8'h40, 20);              send_file();
        build_mp3(0, 8'hF3, 8'h04, 8'hC0, 9);               send_file();
        build_mp3(1, 8'hE3, 8'hF8, 8'h00, 5);               send_file();
        // header cut after its third word
        build_mp3(2, 8'hFB, 8'h90, 8'h40, 0); cut_file(5);  send_file();
        // reserved version then reserved rate, both skipped before a good sync
        build_mp3(0, 8'hEB, 8'h90, 8'h00, 0);
        file_bytes.push_back(8'hFF); file_bytes.push_back(8'hFB);
        file_bytes.push_back(8'h9C); file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF); file_bytes.push_back(8'hFA);
        file_bytes.push_back(8'hE8); file_bytes.push_back(8'h80);
        add_noise(4);                                       send_file();
        // riff tag broken, falls to the sync search
        build_mp3(12, 8'hFB, 8'h50, 8'h00, 3);
        file_bytes[0] = 8'h52; file_bytes[1] = 8'h49; file_bytes[2] = 8'h46;
        file_bytes[3] = 8'h58;                              send_file();
        file_bytes.delete(); file_bytes.push_back(8'hFF);   send_file();
        file_bytes.delete(); file_bytes.push_back(8'h00);   send_file();
    endtask

    task automatic random_file();
        int           pick;
        logic [31:0]  rate;
        logic [15:0]  ch;
        logic [31:0]  dlen;
        logic [31:0]  rates [6] = '{8000, 11025, 16000, 22050, 44100, 48000};
        pick = $urandom_range(9);
        ch   = ($urandom_range(9) == 0) ? 16'($urandom_range(3)) : 16'($urandom_range(1, 2));
        rate = ($urandom_range(5) == 0) ? $urandom_range(7000, 50000) : rates[$urandom_range(5)];
        dlen = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(0, 30));
        if (pick <= 3) begin
            build_wav(($urandom_range(9) == 0) ? 16'($urandom_range(3)) : 16'd1, ch, rate,
                      ($urandom_range(9) == 0) ? 16'($urandom_range(8, 24)) : 16'd16,
                      ($urandom_range(7) == 0) ? $urandom_range(12, 21) : 16,
                      dlen, $urandom_range(0, 24),
                      $urandom_range(1) ? $urandom_range(0, 5) : -1);
        end else if (pick <= 6) begin
            build_mp3($urandom_range(0, 6), {3'b111, 2'($urandom), 2'b01, 1'($urandom)},
                      8'($urandom), 8'($urandom), $urandom_range(0, 30));
        end else if (pick == 7) begin
            file_bytes.delete();
            add_noise($urandom_range(1, 12));
        end else if (pick == 8) begin
            build_wav(1, ch, rate, 16, 16, dlen, 8, $urandom_range(1) ? 1 : -1);
            cut_file($urandom_range(1, file_bytes.size()));
        end else begin
            build_mp3($urandom_range(0, 4), 8'($urandom), 8'($urandom), 8'($urandom), 0);
            cut_file($urandom_range(1, file_bytes.size()));
        end
        send_file();
    endtask

    task automatic test_random_mix(input int words);
        int stop_at;
        stop_at = words_sent + words;
        while (words_sent < stop_at) random_file();
    endtask

    // receiver holds off while one- or two-word streams pile up behind the result queue
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 400;
        repeat (12) begin
            file_bytes.delete();
            add_noise($urandom_range(1, 2));
            send_file();
        end
    endtask

    task automatic wait_drain();
        i_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_data_byte = 8'd0; i_last_byte = 1'b0;
        i_ready = 1'b0; hold_left = 0; send_idle_pct = 0; recv_idle_pct = 0;
        err_count = 0; result_count = 0; words_sent = 0; streams_sent = 0; cycle_count = 0;
        ok_seen = 0; corrupt_seen = 0; unsup_seen = 0; mp3_seen = 0;
        probe_clear();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 21; recv_idle_pct = 88;
        test_wave_directed();
        test_mp3_directed();
        test_random_mix(350);
        send_idle_pct = 88; recv_idle_pct = 21;
        test_random_mix(300);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_mix(300);
        test_backpressure();
        wait_drain();

        $display("covered %0d streams, %0d words, %0d results", streams_sent, words_sent,
                 result_count);
        $display("ok %0d (mp3 %0d), corrupt %0d, unsupported %0d, mismatches %0d",
                 ok_seen, mp3_seen, corrupt_seen, unsup_seen, err_count);
        if (err_count == 0)
            $display("tb_audio_header_probe_unit: clean");
        else
            $display("tb_audio_header_probe_unit: errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ahp_pkg.sv
rtl/ahp_front.sv
rtl/ahp_queue.sv
rtl/ahp_back.sv
rtl/audio_header_probe_unit.sv
test/tb_audio_header_probe_unit.sv
